// ===== design/kso_pkg.sv =====
package kso_pkg;

    // Event codes as carried on the opcode field
    typedef enum logic [2:0] {
        OP_PAN     = 3'd0,
        OP_FLICK   = 3'd1,
        OP_RELEASE = 3'd2,
        OP_RESET   = 3'd3,
        OP_MOTION  = 3'd4,
        OP_ANIM    = 3'd5,
        OP_TIMEOUT = 3'd6,
        OP_NONE    = 3'd7
    } t_op;

    // One queued event
    typedef struct packed {
        t_op                op;
        logic signed [11:0] dx;
        logic signed [11:0] dy;
        logic signed [20:0] fx;
        logic signed [20:0] fy;
    } t_item;

    // Configuration write port
    typedef struct packed {
        logic        we;
        logic [2:0]  idx;
        logic [15:0] data;
    } t_cfg_wr;

    // Register indexes
    localparam logic [2:0] CFG_POLICY   = 3'd0;
    localparam logic [2:0] CFG_DECEL    = 3'd1;
    localparam logic [2:0] CFG_MAX_OV_X = 3'd2;
    localparam logic [2:0] CFG_MAX_OV_Y = 3'd3;
    localparam logic [2:0] CFG_OV_SPEED = 3'd4;
    localparam logic [2:0] CFG_CEILING  = 3'd5;
    localparam logic [2:0] CFG_EXTENT_X = 3'd6;
    localparam logic [2:0] CFG_EXTENT_Y = 3'd7;

    // Reset values of the registers
    localparam logic [15:0] RST_DECEL   = 16'd55706;
    localparam logic [7:0]  RST_MAX_OV  = 8'd150;
    localparam logic [7:0]  RST_OV_SPD  = 8'd130;
    localparam logic [11:0] RST_CEILING = 12'd3500;

    // Overshoot policy codes
    localparam logic [1:0] POL_ALWAYS = 2'd1;
    localparam logic [1:0] POL_NEVER  = 2'd2;

    // Activity codes
    localparam logic [1:0] ACT_IDLE = 2'd0;
    localparam logic [1:0] ACT_PUSH = 2'd1;
    localparam logic [1:0] ACT_AUTO = 2'd2;

    // Timer flag bit positions
    localparam int unsigned TMR_ANIM   = 0;
    localparam int unsigned TMR_MOTION = 1;
    localparam int unsigned TMR_IDLE   = 2;

    localparam logic [7:0] BOUNCE_STEPS = 8'd3;

    localparam logic signed [20:0] VEL_MAX = 21'sh0FFFFF;
    localparam logic signed [20:0] VEL_MIN = 21'sh100000;
    localparam logic signed [20:0] ONE_VEL = 21'sd256;

endpackage

// ===== design/kso_front.sv =====
module kso_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [2:0]          i_opcode,
    input  logic signed [11:0]  i_delta_x,
    input  logic signed [11:0]  i_delta_y,
    input  logic signed [20:0]  i_fling_x,
    input  logic signed [20:0]  i_fling_y,
    output logic                o_q_valid,
    output kso_pkg::t_item      o_q_item,
    input  logic                i_q_pop
);

    // two-entry queue between decode and execution
    kso_pkg::t_item r_mem [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_cnt;
    kso_pkg::t_item n_item;
    logic           push;

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_item   = r_mem[r_rptr];

    always_comb begin
        n_item    = '0;
        n_item.op = kso_pkg::t_op'(i_opcode);
        // only the fields an event uses are kept
        if (n_item.op == kso_pkg::OP_PAN) begin
            n_item.dx = i_delta_x;
            n_item.dy = i_delta_y;
        end
        if (n_item.op == kso_pkg::OP_FLICK) begin
            n_item.fx = i_fling_x;
            n_item.fy = i_fling_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (i_q_pop) begin
                r_rptr <= !r_rptr;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_cnt != 2'd0) else $error("pop from empty queue");

endmodule

// ===== design/kso_back.sv =====
module kso_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kso_pkg::t_cfg_wr    i_cfg,
    input  logic                i_q_valid,
    input  kso_pkg::t_item      i_q_item,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [15:0]         o_scroll_x,
    output logic [15:0]         o_scroll_y,
    output logic signed [8:0]   o_shown_overshoot_x,
    output logic signed [8:0]   o_shown_overshoot_y,
    output logic [1:0]          o_activity,
    output logic                o_activity_changed,
    output logic [2:0]          o_timers_armed
);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_MOVE, S_HALT, S_HALT2, S_ANIM2, S_ANIM3, S_OUT
    } t_state;

    typedef struct packed {
        logic [15:0]       pos;
        logic signed [8:0] ov;
    } t_axis;

    function automatic t_axis axis_move(input logic [15:0] pos, input logic signed [8:0] ov,
                                        input logic [15:0] ext, input logic [7:0] mo,
                                        input logic signed [16:0] d, input logic allow);
        logic signed [19:0] tgt;
        logic signed [19:0] clp;
        logic signed [19:0] dif;
        logic signed [19:0] mos;
        t_axis              res;
        tgt = $signed({4'b0, pos}) - 20'(ov) - 20'(d);
        if (tgt < 20'sd0) begin
            clp = '0;
        end else if (tgt > $signed({4'b0, ext})) begin
            clp = $signed({4'b0, ext});
        end else begin
            clp = tgt;
        end
        dif = allow ? (clp - tgt) : 20'sd0;
        mos = $signed({12'b0, mo});
        if (dif > mos) begin
            dif = mos;
        end else if (dif < -mos) begin
            dif = -mos;
        end
        res.pos = clp[15:0];
        res.ov  = dif[8:0];
        return res;
    endfunction

    function automatic logic [20:0] mag(input logic signed [20:0] v);
        return v[20] ? (~v + 21'd1) : v;
    endfunction

    // round half away from zero to whole pixels
    function automatic logic signed [16:0] vel_pixels(input logic signed [20:0] v);
        logic [21:0] s;
        logic [13:0] r;
        s = {1'b0, mag(v)} + 22'd128;
        r = s[21:8];
        return v[20] ? -$signed({3'b0, r}) : $signed({3'b0, r});
    endfunction

    // |ov| * 1024 / 5 by reciprocal, exact below 2^18, with the sign opposite to ov
    function automatic logic signed [20:0] back_speed(input logic signed [8:0] ov);
        logic [8:0]  m;
        logic [34:0] p;
        logic [16:0] q;
        m = ov[8] ? 9'(-ov) : 9'(ov);
        p = {16'b0, m, 10'b0} * 35'd52429;
        q = p[34:18];
        return (ov > 9'sd0) ? -$signed({4'b0, q}) : $signed({4'b0, q});
    endfunction

    function automatic logic signed [20:0] decay(input logic signed [20:0] v,
                                                 input logic [15:0] f, input logic [11:0] c);
        logic [20:0] m;
        logic [23:0] lhs;
        logic [23:0] rhs;
        logic [36:0] p;
        logic [20:0] r;
        m   = mag(v);
        lhs = 24'(m) * 24'd5;
        rhs = {2'b0, c, 10'b0};
        p   = 37'(m) * 37'(f);
        r   = p[36:16];
        if (lhs < rhs) begin
            return v[20] ? $signed(~r + 21'd1) : $signed(r);
        end
        return v;
    endfunction

    // velocity after an overshooting animation step
    function automatic logic signed [20:0] over_vel(input logic signed [8:0] ov,
                                                    input logic [7:0] mo,
                                                    input logic signed [20:0] v,
                                                    input logic [7:0] nb,
                                                    input logic [7:0] spd);
        logic signed [20:0] r;
        logic signed [20:0] lim;
        logic signed [8:0]  mos;
        mos = $signed({1'b0, mo});
        lim = $signed({5'b0, spd, 8'b0});
        if (nb < kso_pkg::BOUNCE_STEPS) begin
            // over / mo truncates to -1, 0 or 1 since |over| <= mo
            if (mo != 8'd0 && ov == mos) begin
                r = v;
            end else if (mo != 8'd0 && ov == -mos) begin
                r = (v == kso_pkg::VEL_MIN) ? kso_pkg::VEL_MAX : -v;
            end else begin
                r = '0;
            end
        end else begin
            r = back_speed(ov);
            if (r < 21'sd0 && r > -kso_pkg::ONE_VEL) begin
                r = -kso_pkg::ONE_VEL;
            end else if (r > 21'sd0 && r < kso_pkg::ONE_VEL) begin
                r = kso_pkg::ONE_VEL;
            end
        end
        if (r > lim) begin
            r = lim;
        end else if (r < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

    t_state              r_state;
    t_state              r_ret;
    kso_pkg::t_item      r_item;
    logic [1:0]          r_before;

    logic [1:0]          r_policy;
    logic [15:0]         r_decel;
    logic [7:0]          r_mox;
    logic [7:0]          r_moy;
    logic [7:0]          r_ovspd;
    logic [11:0]         r_ceil;
    logic [15:0]         r_ext_x;
    logic [15:0]         r_ext_y;

    logic                r_push;
    logic [1:0]          r_act;
    logic [15:0]         r_pos_x;
    logic [15:0]         r_pos_y;
    logic signed [8:0]   r_ovx;
    logic signed [8:0]   r_ovy;
    logic signed [15:0]  r_pend_x;
    logic signed [15:0]  r_pend_y;
    logic signed [20:0]  r_vx;
    logic signed [20:0]  r_vy;
    logic [7:0]          r_bounce;
    logic [2:0]          r_tmr;
    logic signed [16:0]  r_mdx;
    logic signed [16:0]  r_mdy;

    logic                r_ovld;
    logic [15:0]         r_o_sx;
    logic [15:0]         r_o_sy;
    logic signed [8:0]   r_o_ox;
    logic signed [8:0]   r_o_oy;
    logic [1:0]          r_o_act;
    logic                r_o_chg;
    logic [2:0]          r_o_tmr;

    logic                allow_x;
    logic                allow_y;
    t_axis               mv_x;
    t_axis               mv_y;
    logic signed [11:0]  pan_dx;
    logic signed [11:0]  pan_dy;
    logic signed [16:0]  psum_x;
    logic signed [16:0]  psum_y;
    logic signed [15:0]  n_pend_x;
    logic signed [15:0]  n_pend_y;
    logic [7:0]          n_bounce;
    logic signed [20:0]  bs_x;
    logic signed [20:0]  bs_y;
    logic signed [20:0]  dec_x;
    logic signed [20:0]  dec_y;
    logic                ovr;

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    assign allow_x = (r_ext_x != 16'd0) || (r_policy == kso_pkg::POL_ALWAYS);
    assign allow_y = (r_ext_y != 16'd0) || (r_policy == kso_pkg::POL_ALWAYS);
    assign mv_x    = axis_move(r_pos_x, r_ovx, r_ext_x, r_mox, r_mdx, allow_x);
    assign mv_y    = axis_move(r_pos_y, r_ovy, r_ext_y, r_moy, r_mdy, allow_y);

    assign pan_dx  = allow_x ? r_item.dx : 12'sd0;
    assign pan_dy  = allow_y ? r_item.dy : 12'sd0;
    assign psum_x  = 17'(r_pend_x) + 17'(pan_dx);
    assign psum_y  = 17'(r_pend_y) + 17'(pan_dy);

    always_comb begin
        if (psum_x > 17'sd32767) begin
            n_pend_x = 16'sh7FFF;
        end else if (psum_x < -17'sd32768) begin
            n_pend_x = 16'sh8000;
        end else begin
            n_pend_x = psum_x[15:0];
        end
        if (psum_y > 17'sd32767) begin
            n_pend_y = 16'sh7FFF;
        end else if (psum_y < -17'sd32768) begin
            n_pend_y = 16'sh8000;
        end else begin
            n_pend_y = psum_y[15:0];
        end
    end

    assign n_bounce = (r_bounce == 8'd255) ? r_bounce : r_bounce + 8'd1;
    assign bs_x     = back_speed(r_ovx);
    assign bs_y     = back_speed(r_ovy);
    assign dec_x    = decay(r_vx, r_decel, r_ceil);
    assign dec_y    = decay(r_vy, r_decel, r_ceil);
    assign ovr      = (r_ovx != 9'sd0) || (r_ovy != 9'sd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_OUT;
            r_policy <= 2'd0;
            r_decel  <= kso_pkg::RST_DECEL;
            r_mox    <= kso_pkg::RST_MAX_OV;
            r_moy    <= kso_pkg::RST_MAX_OV;
            r_ovspd  <= kso_pkg::RST_OV_SPD;
            r_ceil   <= kso_pkg::RST_CEILING;
            r_ext_x  <= '0;
            r_ext_y  <= '0;
            r_push   <= 1'b0;
            r_act    <= kso_pkg::ACT_IDLE;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_ovx    <= '0;
            r_ovy    <= '0;
            r_pend_x <= '0;
            r_pend_y <= '0;
            r_vx     <= '0;
            r_vy     <= '0;
            r_bounce <= '0;
            r_tmr    <= '0;
            r_ovld   <= 1'b0;
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    kso_pkg::CFG_POLICY:   r_policy <= i_cfg.data[1:0];
                    kso_pkg::CFG_DECEL:    r_decel  <= i_cfg.data;
                    kso_pkg::CFG_MAX_OV_X: r_mox    <= i_cfg.data[7:0];
                    kso_pkg::CFG_MAX_OV_Y: r_moy    <= i_cfg.data[7:0];
                    kso_pkg::CFG_OV_SPEED: r_ovspd  <= i_cfg.data[7:0];
                    kso_pkg::CFG_CEILING:  r_ceil   <= i_cfg.data[11:0];
                    kso_pkg::CFG_EXTENT_X: r_ext_x  <= i_cfg.data;
                    kso_pkg::CFG_EXTENT_Y: r_ext_y  <= i_cfg.data;
                    default: ;
                endcase
            end

            // output register: loaded from S_OUT, emptied when taken
            if (r_state == S_OUT && (!r_ovld || !i_out_stall)) begin
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item   <= i_q_item;
                        r_before <= r_act;
                        r_state  <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    case (r_item.op)
                        kso_pkg::OP_PAN: begin
                            r_tmr[kso_pkg::TMR_IDLE] <= 1'b0;
                            if (r_tmr[kso_pkg::TMR_MOTION]) begin
                                r_pend_x <= n_pend_x;
                                r_pend_y <= n_pend_y;
                                r_state  <= S_OUT;
                            end else begin
                                r_push   <= 1'b1;
                                r_act    <= kso_pkg::ACT_PUSH;
                                r_pend_x <= '0;
                                r_pend_y <= '0;
                                r_tmr[kso_pkg::TMR_MOTION] <= 1'b1;
                                r_mdx    <= 17'(pan_dx);
                                r_mdy    <= 17'(pan_dy);
                                r_ret    <= S_OUT;
                                r_state  <= S_MOVE;
                            end
                        end
                        kso_pkg::OP_FLICK: begin
                            r_tmr[kso_pkg::TMR_IDLE] <= 1'b0;
                            r_tmr[kso_pkg::TMR_ANIM] <= 1'b1;
                            r_pend_x <= '0;
                            r_pend_y <= '0;
                            r_push   <= 1'b0;
                            r_act    <= kso_pkg::ACT_AUTO;
                            r_vx     <= r_item.fx;
                            r_vy     <= r_item.fy;
                            r_state  <= S_OUT;
                        end
                        kso_pkg::OP_RELEASE: begin
                            r_state <= S_HALT;
                        end
                        kso_pkg::OP_RESET: begin
                            r_act    <= kso_pkg::ACT_IDLE;
                            r_tmr    <= '0;
                            r_vx     <= '0;
                            r_vy     <= '0;
                            r_ovx    <= '0;
                            r_ovy    <= '0;
                            r_bounce <= '0;
                            r_state  <= S_OUT;
                        end
                        kso_pkg::OP_MOTION: begin
                            if (r_tmr[kso_pkg::TMR_MOTION]) begin
                                r_tmr[kso_pkg::TMR_MOTION] <= 1'b0;
                                r_tmr[kso_pkg::TMR_IDLE]   <= 1'b1;
                                // an empty pending move leaves overshoot alone
                                if (r_pend_x != 16'sd0 || r_pend_y != 16'sd0) begin
                                    r_mdx   <= 17'(r_pend_x);
                                    r_mdy   <= 17'(r_pend_y);
                                    r_ret   <= S_OUT;
                                    r_state <= S_MOVE;
                                end else begin
                                    r_state <= S_OUT;
                                end
                            end else begin
                                r_state <= S_OUT;
                            end
                        end
                        kso_pkg::OP_ANIM: begin
                            if (r_tmr[kso_pkg::TMR_ANIM]) begin
                                if (r_push && !ovr) begin
                                    r_state <= S_HALT;
                                end else begin
                                    r_mdx   <= vel_pixels(r_vx);
                                    r_mdy   <= vel_pixels(r_vy);
                                    r_ret   <= S_ANIM2;
                                    r_state <= S_MOVE;
                                end
                            end else begin
                                r_state <= S_OUT;
                            end
                        end
                        kso_pkg::OP_TIMEOUT: begin
                            if (r_tmr[kso_pkg::TMR_IDLE] && !r_tmr[kso_pkg::TMR_MOTION]
                                && !r_tmr[kso_pkg::TMR_ANIM]) begin
                                r_state <= S_HALT;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end
                        default: r_state <= S_OUT;
                    endcase
                end

                S_MOVE: begin
                    r_pos_x <= mv_x.pos;
                    r_ovx   <= mv_x.ov;
                    r_pos_y <= mv_y.pos;
                    r_ovy   <= mv_y.ov;
                    r_state <= r_ret;
                end

                S_HALT: begin
                    r_tmr[kso_pkg::TMR_IDLE] <= 1'b0;
                    r_tmr[kso_pkg::TMR_ANIM] <= 1'b0;
                    if (r_tmr[kso_pkg::TMR_MOTION]) begin
                        r_tmr[kso_pkg::TMR_MOTION] <= 1'b0;
                        r_mdx   <= 17'(r_pend_x);
                        r_mdy   <= 17'(r_pend_y);
                        r_ret   <= S_HALT2;
                        r_state <= S_MOVE;
                    end else begin
                        r_state <= S_HALT2;
                    end
                end

                S_HALT2: begin
                    r_pend_x <= '0;
                    r_pend_y <= '0;
                    r_push   <= 1'b0;
                    if (ovr) begin
                        // bounce back from the edge
                        r_bounce <= kso_pkg::BOUNCE_STEPS;
                        r_act    <= kso_pkg::ACT_AUTO;
                        r_tmr[kso_pkg::TMR_ANIM] <= 1'b1;
                        if (r_ovx != 9'sd0) begin
                            r_vx <= bs_x;
                        end
                        if (r_ovy != 9'sd0) begin
                            r_vy <= bs_y;
                        end
                    end else begin
                        r_vx  <= '0;
                        r_vy  <= '0;
                        r_act <= kso_pkg::ACT_IDLE;
                    end
                    r_state <= S_OUT;
                end

                S_ANIM2: begin
                    if (ovr) begin
                        r_bounce <= n_bounce;
                        r_vx <= over_vel(r_ovx, r_mox, r_vx, n_bounce, r_ovspd);
                        r_vy <= over_vel(r_ovy, r_moy, r_vy, n_bounce, r_ovspd);
                        r_state  <= S_OUT;
                    end else if (r_act == kso_pkg::ACT_AUTO) begin
                        r_bounce <= '0;
                        r_vx     <= dec_x;
                        r_vy     <= dec_y;
                        r_state  <= S_ANIM3;
                    end else if (!r_push) begin
                        r_state <= S_HALT;
                    end else begin
                        r_state <= S_OUT;
                    end
                end

                S_ANIM3: begin
                    // stop once both axes are below one pixel per tick
                    if (r_vx > -kso_pkg::ONE_VEL && r_vx < kso_pkg::ONE_VEL &&
                        r_vy > -kso_pkg::ONE_VEL && r_vy < kso_pkg::ONE_VEL) begin
                        r_state <= S_HALT;
                    end else begin
                        r_state <= S_OUT;
                    end
                end

                S_OUT: begin
                    if (!r_ovld || !i_out_stall) begin
                        r_o_sx  <= r_pos_x;
                        r_o_sy  <= r_pos_y;
                        r_o_ox  <= (r_policy == kso_pkg::POL_NEVER) ? 9'sd0 : r_ovx;
                        r_o_oy  <= (r_policy == kso_pkg::POL_NEVER) ? 9'sd0 : r_ovy;
                        r_o_act <= r_act;
                        r_o_chg <= (r_act != r_before);
                        r_o_tmr <= r_tmr;
                        r_state <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid         = r_ovld;
    assign o_scroll_x          = r_o_sx;
    assign o_scroll_y          = r_o_sy;
    assign o_shown_overshoot_x = r_o_ox;
    assign o_shown_overshoot_y = r_o_oy;
    assign o_activity          = r_o_act;
    assign o_activity_changed  = r_o_chg;
    assign o_timers_armed      = r_o_tmr;

    a_pop_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_state == S_EXEC) else $error("popped item not executed");

    a_over_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MOVE |=>
            ($signed({r_ovx[8], r_ovx}) <= $signed({2'b0, r_mox})) &&
            ($signed({r_ovx[8], r_ovx}) >= -$signed({2'b0, r_mox})) &&
            ($signed({r_ovy[8], r_ovy}) <= $signed({2'b0, r_moy})) &&
            ($signed({r_ovy[8], r_ovy}) >= -$signed({2'b0, r_moy})))
        else $error("overshoot beyond limit after move");

    a_act_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_act[1] && r_act[0])) else $error("bad activity code");

endmodule

// ===== design/kinetic_scroll_overshoot_engine_unit.sv =====
// An accepted event is written into the queue, popped in S_IDLE, run in S_EXEC and any
//   further sequencer states, and then loaded into the output register from S_OUT.
// The sequencer in kso_back takes a new item only once it is back in S_IDLE after the last.
// A two-entry queue keeps input accept running, until it is full, while the sequencer or the output waits.
// Reset: synchronous, active low; clears the scroller state and loads register defaults.
module kinetic_scroll_overshoot_engine_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write port
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    // event channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [2:0]          i_opcode,
    input  logic signed [11:0]  i_delta_x,
    input  logic signed [11:0]  i_delta_y,
    input  logic signed [20:0]  i_fling_x,
    input  logic signed [20:0]  i_fling_y,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [15:0]         o_scroll_x,
    output logic [15:0]         o_scroll_y,
    output logic signed [8:0]   o_shown_overshoot_x,
    output logic signed [8:0]   o_shown_overshoot_y,
    output logic [1:0]          o_activity,
    output logic                o_activity_changed,
    output logic [2:0]          o_timers_armed
);

    kso_pkg::t_item   q_item;
    kso_pkg::t_cfg_wr cfg;
    logic             q_valid;
    logic             q_pop;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // front: accept and decode events into the queue
    kso_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_opcode   (i_opcode),
        .i_delta_x  (i_delta_x),
        .i_delta_y  (i_delta_y),
        .i_fling_x  (i_fling_x),
        .i_fling_y  (i_fling_y),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    // back: config registers, scroller state, sequencer and output register
    kso_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (cfg),
        .i_q_valid           (q_valid),
        .i_q_item            (q_item),
        .o_q_pop             (q_pop),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_scroll_x          (o_scroll_x),
        .o_scroll_y          (o_scroll_y),
        .o_shown_overshoot_x (o_shown_overshoot_x),
        .o_shown_overshoot_y (o_shown_overshoot_y),
        .o_activity          (o_activity),
        .o_activity_changed  (o_activity_changed),
        .o_timers_armed      (o_timers_armed)
    );

endmodule
